// ===== sv/tun_pkg.sv =====
// Shared constants and types for the triangle unit normal pipeline.
`default_nettype none
package tun_pkg;

    localparam int COORD_WIDTH_DEF      = 16;
    localparam int NORMAL_FRAC_BITS_DEF = 14;

    // Largest edge magnitude is kept within this many bits.
    localparam int EDGE_BITS = 16;
    // Cross product magnitudes stay below 2^33.
    localparam int CMAG_BITS = 33;
    localparam int CPOS_BITS = 6;
    // The largest normalized magnitude lies in [2^30, 2^31), unless all are zero.
    localparam int NORM_BITS = 31;
    localparam int NORM_TOP  = 30;
    localparam int SQ_BITS   = 2 * NORM_BITS;
    localparam int SUM_BITS  = 64;
    localparam int ROOT_BITS = 32;
    localparam int REM_BITS  = ROOT_BITS + 1;

    typedef struct packed {
        logic [2:0][NORM_BITS-1:0] mag;
        logic [2:0]                neg;
        logic                      degen;
    } side_t;

endpackage
`default_nettype wire

// ===== sv/tun_front.sv =====
// Edge vectors, edge range limiting and the cross product, in five register stages.
`default_nettype none
module tun_front #(
    parameter int CW = tun_pkg::COORD_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 ce,
    input  logic                                 in_valid,
    input  logic [9*CW-1:0]                      coords,
    output logic                                 out_valid,
    output logic [2:0][tun_pkg::CMAG_BITS-1:0]   cmag,
    output logic [2:0]                           cneg
);
    import tun_pkg::*;

    localparam int DW = CW + 1;
    localparam int SW = $clog2(DW + 1);

    function automatic logic [DW-1:0] mag_of(input logic signed [DW-1:0] v);
        return v[DW-1] ? DW'(-v) : DW'(v);
    endfunction

    function automatic logic [SW-1:0] limit_shift(input logic [DW-1:0] v);
        logic [SW-1:0] bl;
        bl = '0;
        for (int k = 0; k < DW; k++)
        begin
            if (v[k])
            begin
                bl = SW'(k + 1);
            end
        end
        return (int'(bl) > EDGE_BITS) ? SW'(int'(bl) - EDGE_BITS) : '0;
    endfunction

    function automatic logic signed [EDGE_BITS:0] limit_edge(input logic signed [DW-1:0] v,
                                                             input logic [SW-1:0] s);
        logic [DW-1:0]           m;
        logic [DW+EDGE_BITS-1:0] wide;
        logic [EDGE_BITS:0]      e;
        m    = mag_of(v) >> s;
        wide = {{EDGE_BITS{1'b0}}, m};
        e    = {1'b0, wide[EDGE_BITS-1:0]};
        return v[DW-1] ? $signed(-e) : $signed(e);
    endfunction

    logic [4:0] vld_reg;

    logic signed [DW-1:0] da_next [3], db_next [3];
    logic signed [DW-1:0] da1_reg [3], db1_reg [3];
    logic signed [DW-1:0] da2_reg [3], db2_reg [3];
    logic [SW-1:0]        sa_next, sb_next, sa_reg, sb_reg;
    logic signed [EDGE_BITS:0] ea_next [3], eb_next [3], ea_reg [3], eb_reg [3];
    logic signed [2*EDGE_BITS+1:0] p_next [3], q_next [3], p_reg [3], q_reg [3];
    logic signed [2*EDGE_BITS+2:0] c_next [3];
    logic [2:0][CMAG_BITS-1:0] cmag_next, cmag_reg;
    logic [2:0]                cneg_next, cneg_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            da_next[i] = DW'($signed(coords[i*CW +: CW])) - DW'($signed(coords[(6+i)*CW +: CW]));
            db_next[i] = DW'($signed(coords[(3+i)*CW +: CW]))
                       - DW'($signed(coords[(6+i)*CW +: CW]));
        end
        sa_next = limit_shift(mag_of(da1_reg[0]) | mag_of(da1_reg[1]) | mag_of(da1_reg[2]));
        sb_next = limit_shift(mag_of(db1_reg[0]) | mag_of(db1_reg[1]) | mag_of(db1_reg[2]));
        for (int i = 0; i < 3; i++)
        begin
            ea_next[i] = limit_edge(da2_reg[i], sa_reg);
            eb_next[i] = limit_edge(db2_reg[i], sb_reg);
        end
        p_next[0] = ea_reg[1] * eb_reg[2];
        q_next[0] = eb_reg[1] * ea_reg[2];
        p_next[1] = ea_reg[2] * eb_reg[0];
        q_next[1] = ea_reg[0] * eb_reg[2];
        p_next[2] = ea_reg[0] * eb_reg[1];
        q_next[2] = eb_reg[0] * ea_reg[1];
        for (int i = 0; i < 3; i++)
        begin
            c_next[i]    = (2*EDGE_BITS+3)'(p_reg[i]) - (2*EDGE_BITS+3)'(q_reg[i]);
            cneg_next[i] = c_next[i][2*EDGE_BITS+2];
            cmag_next[i] = cneg_next[i] ? CMAG_BITS'(-c_next[i]) : CMAG_BITS'(c_next[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ce)
        begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            da1_reg  <= da_next;
            db1_reg  <= db_next;
            da2_reg  <= da1_reg;
            db2_reg  <= db1_reg;
            sa_reg   <= sa_next;
            sb_reg   <= sb_next;
            ea_reg   <= ea_next;
            eb_reg   <= eb_next;
            p_reg    <= p_next;
            q_reg    <= q_next;
            cmag_reg <= cmag_next;
            cneg_reg <= cneg_next;
        end
    end

    assign out_valid = vld_reg[4];
    assign cmag      = cmag_reg;
    assign cneg      = cneg_reg;

endmodule
`default_nettype wire

// ===== sv/tun_norm.sv =====
// Block normalization of the cross product and the sum of squares, in four stages.
`default_nettype none
module tun_norm (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 ce,
    input  logic                                 in_valid,
    input  logic [2:0][tun_pkg::CMAG_BITS-1:0]   cmag,
    input  logic [2:0]                           cneg,
    output logic                                 out_valid,
    output logic [tun_pkg::SUM_BITS-1:0]         sum,
    output tun_pkg::side_t                       side
);
    import tun_pkg::*;

    localparam int WIDE_BITS = CMAG_BITS + NORM_TOP;

    logic [3:0] vld_reg;

    logic [CMAG_BITS-1:0]      all_bits;
    logic [CPOS_BITS-1:0]      pos_next, pos_reg;
    logic                      degen_next, degen_reg;
    logic [2:0][CMAG_BITS-1:0] mag_reg;
    logic [2:0]                neg_reg;
    logic [CPOS_BITS-1:0]      rsh, lsh;
    logic [WIDE_BITS-1:0]      wide;
    side_t                     side_next, side1_reg, side2_reg;
    logic [SQ_BITS-1:0]        sq_next [3], sq_reg [3];
    logic [SUM_BITS-1:0]       sum_next, sum_reg;

    always_comb
    begin
        all_bits = cmag[0] | cmag[1] | cmag[2];
        pos_next = '0;
        for (int k = 0; k < CMAG_BITS; k++)
        begin
            if (all_bits[k])
            begin
                pos_next = CPOS_BITS'(k);
            end
        end
        degen_next = (all_bits == '0);

        rsh = (pos_reg > CPOS_BITS'(NORM_TOP)) ? pos_reg - CPOS_BITS'(NORM_TOP) : '0;
        lsh = (pos_reg > CPOS_BITS'(NORM_TOP)) ? '0 : CPOS_BITS'(NORM_TOP) - pos_reg;
        wide = '0;
        for (int i = 0; i < 3; i++)
        begin
            wide = ({{NORM_TOP{1'b0}}, mag_reg[i]} >> rsh) << lsh;
            side_next.mag[i] = wide[NORM_BITS-1:0];
        end
        side_next.neg   = neg_reg;
        side_next.degen = degen_reg;

        for (int i = 0; i < 3; i++)
        begin
            sq_next[i] = SQ_BITS'(side1_reg.mag[i]) * SQ_BITS'(side1_reg.mag[i]);
        end
        sum_next = SUM_BITS'(sq_reg[0]) + SUM_BITS'(sq_reg[1]) + SUM_BITS'(sq_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ce)
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            pos_reg   <= pos_next;
            degen_reg <= degen_next;
            mag_reg   <= cmag;
            neg_reg   <= cneg;
            side1_reg <= side_next;
            sq_reg    <= sq_next;
            side2_reg <= side1_reg;
            sum_reg   <= sum_next;
            side      <= side2_reg;
        end
    end

    assign out_valid = vld_reg[3];
    assign sum       = sum_reg;

endmodule
`default_nettype wire

// ===== sv/tun_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module tun_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          ce,
    input  logic                          in_valid,
    input  logic [tun_pkg::SUM_BITS-1:0]  sum,
    input  tun_pkg::side_t                side_in,
    output logic                          out_valid,
    output logic [tun_pkg::ROOT_BITS-1:0] root,
    output tun_pkg::side_t                side_out
);
    import tun_pkg::*;

    localparam int STEPS = ROOT_BITS;

    logic [STEPS-1:0]     vld_reg;
    logic [REM_BITS-1:0]  rem_reg  [STEPS], rem_next  [STEPS];
    logic [ROOT_BITS-1:0] root_reg [STEPS], root_next [STEPS];
    logic [SUM_BITS-1:0]  num_reg  [STEPS], num_next  [STEPS];
    side_t                side_reg [STEPS], side_next [STEPS];
    logic [STEPS-1:0]     vld_next;

    always_comb
    begin
        logic [REM_BITS-1:0]  r;
        logic [ROOT_BITS-1:0] q;
        logic [SUM_BITS-1:0]  n;
        logic [REM_BITS+1:0]  t, trial;
        for (int s = 0; s < STEPS; s++)
        begin
            if (s == 0)
            begin
                r = '0;
                q = '0;
                n = sum;
                side_next[s] = side_in;
                vld_next[s]  = in_valid;
            end
            else
            begin
                r = rem_reg[s-1];
                q = root_reg[s-1];
                n = num_reg[s-1];
                side_next[s] = side_reg[s-1];
                vld_next[s]  = vld_reg[s-1];
            end
            t     = {r, n[SUM_BITS-1 -: 2]};
            trial = {1'b0, q, 2'b01};
            if (t >= trial)
            begin
                rem_next[s]  = REM_BITS'(t - trial);
                root_next[s] = {q[ROOT_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next[s]  = t[REM_BITS-1:0];
                root_next[s] = {q[ROOT_BITS-2:0], 1'b0};
            end
            num_next[s] = n << 2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ce)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            num_reg  <= num_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = vld_reg[STEPS-1];
    assign root      = root_reg[STEPS-1];
    assign side_out  = side_reg[STEPS-1];

endmodule
`default_nettype wire

// ===== sv/tun_div.sv =====
// Three pipelined restoring dividers that scale each magnitude by the length.
`default_nettype none
module tun_div #(
    parameter int FB = tun_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          ce,
    input  logic                          in_valid,
    input  logic [tun_pkg::ROOT_BITS-1:0] len,
    input  tun_pkg::side_t                side_in,
    output logic                          out_valid,
    output logic [2:0][FB:0]              quo,
    output tun_pkg::side_t                side_out
);
    import tun_pkg::*;

    localparam int QW = FB + 1;
    localparam int NW = NORM_BITS + 1 + FB;

    logic [NW-1:0]        num [3];
    logic [ROOT_BITS-1:0] rem0_next [3], rem0_reg [3];
    logic [QW-1:0]        low0_next [3], low0_reg [3];
    logic [ROOT_BITS-1:0] len0_reg;
    side_t                side0_reg;
    logic                 vld0_reg;

    logic [ROOT_BITS-1:0] rem_reg [QW][3], rem_next [QW][3];
    logic [QW-1:0]        low_reg [QW][3], low_next [QW][3];
    logic [QW-1:0]        q_reg   [QW][3], q_next   [QW][3];
    logic [ROOT_BITS-1:0] len_reg [QW], len_next [QW];
    side_t                side_reg [QW], side_next [QW];
    logic [QW-1:0]        vld_reg, vld_next;

    always_comb
    begin
        logic [ROOT_BITS-1:0] r;
        logic [QW-1:0]        lo, q;
        logic [ROOT_BITS:0]   t;
        logic                 ge;
        for (int i = 0; i < 3; i++)
        begin
            // Numerator is the magnitude scaled up plus half the length, for rounding.
            num[i]       = (NW'(side_in.mag[i]) << FB) + NW'(len >> 1);
            rem0_next[i] = ROOT_BITS'(num[i][NW-1:QW]);
            low0_next[i] = num[i][QW-1:0];
        end
        for (int s = 0; s < QW; s++)
        begin
            len_next[s]  = (s == 0) ? len0_reg  : len_reg[s-1];
            side_next[s] = (s == 0) ? side0_reg : side_reg[s-1];
            vld_next[s]  = (s == 0) ? vld0_reg  : vld_reg[s-1];
            for (int i = 0; i < 3; i++)
            begin
                r  = (s == 0) ? rem0_reg[i] : rem_reg[s-1][i];
                lo = (s == 0) ? low0_reg[i] : low_reg[s-1][i];
                q  = (s == 0) ? '0          : q_reg[s-1][i];
                t  = {r, lo[QW-1]};
                ge = (t >= {1'b0, len_next[s]});
                rem_next[s][i] = ge ? ROOT_BITS'(t - {1'b0, len_next[s]}) : t[ROOT_BITS-1:0];
                q_next[s][i]   = {q[QW-2:0], ge};
                low_next[s][i] = lo << 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
            vld_reg  <= '0;
        end
        else if (ce)
        begin
            vld0_reg <= in_valid;
            vld_reg  <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            rem0_reg  <= rem0_next;
            low0_reg  <= low0_next;
            len0_reg  <= len;
            side0_reg <= side_in;
            rem_reg   <= rem_next;
            low_reg   <= low_next;
            q_reg     <= q_next;
            len_reg   <= len_next;
            side_reg  <= side_next;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            quo[i] = q_reg[QW-1][i];
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign side_out  = side_reg[QW-1];

endmodule
`default_nettype wire

// ===== sv/triangle_unit_normal.sv =====
// Path from input transfer to result: front, norm, sqrt, div, then the output register.
// Throughput: one triangle per cycle unless stalled; all stages are registers, one enable.
// The depth is set by the 32-stage square root and the NORMAL_FRAC_BITS + 1 divider steps.
// The whole pipeline holds while a result waits on m_tready.
// Reset (rst_n, asynchronous, active low) clears only the valid bits; data is not cleared.
`default_nettype none
module triangle_unit_normal #(
    parameter int COORD_WIDTH      = tun_pkg::COORD_WIDTH_DEF,
    parameter int NORMAL_FRAC_BITS = tun_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // From bit 0 up: first_x, first_y, first_z, second_x, second_y, second_z,
    // origin_x, origin_y, origin_z, each COORD_WIDTH bits, then zero fill to a byte.
    input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // From bit 0 up: normal_x, normal_y, normal_z, each NORMAL_FRAC_BITS + 2 bits,
    // then zero fill to a byte.
    output logic [((3*(NORMAL_FRAC_BITS+2)+7)/8)*8-1:0] m_tdata,
    // Bit 0: degenerate.
    output logic [0:0] m_tuser
);
    import tun_pkg::*;

    localparam int OW  = NORMAL_FRAC_BITS + 2;
    localparam int MTW = ((3*OW+7)/8)*8;

    // One enable moves every stage; it is high whenever the output register
    // is empty or its transfer completes in this cycle.
    logic ce;

    logic                      front_valid;
    logic [2:0][CMAG_BITS-1:0] front_mag;
    logic [2:0]                front_neg;

    logic                 norm_valid;
    logic [SUM_BITS-1:0]  norm_sum;
    side_t                norm_side;

    logic                 sqrt_valid;
    logic [ROOT_BITS-1:0] sqrt_root;
    side_t                sqrt_side;

    logic                          div_valid;
    logic [2:0][NORMAL_FRAC_BITS:0] div_quo;
    side_t                         div_side;

    logic             out_valid_reg;
    logic [MTW-1:0]   tdata_next, tdata_reg;
    logic             degen_reg;
    logic [OW-1:0]    comp;

    assign ce       = !out_valid_reg || m_tready;
    assign s_tready = ce;

    // Edges, edge limiting and the cross product.
    tun_front #(
        .CW (COORD_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (s_tvalid),
        .coords    (s_tdata[9*COORD_WIDTH-1:0]),
        .out_valid (front_valid),
        .cmag      (front_mag),
        .cneg      (front_neg)
    );

    // Shift the three magnitudes together so the largest has its top bit at 30,
    // then form the sum of squares.
    tun_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (front_valid),
        .cmag      (front_mag),
        .cneg      (front_neg),
        .out_valid (norm_valid),
        .sum       (norm_sum),
        .side      (norm_side)
    );

    // Euclidean length, floor of the square root.
    tun_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (norm_valid),
        .sum       (norm_sum),
        .side_in   (norm_side),
        .out_valid (sqrt_valid),
        .root      (sqrt_root),
        .side_out  (sqrt_side)
    );

    // Each magnitude divided by the length with rounding half away from zero.
    tun_div #(
        .FB (NORMAL_FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (sqrt_valid),
        .len       (sqrt_root),
        .side_in   (sqrt_side),
        .out_valid (div_valid),
        .quo       (div_quo),
        .side_out  (div_side)
    );

    // Restore the signs and force zeros for a zero-length cross product; the
    // dividers see a zero length then and their quotients mean nothing.
    always_comb
    begin
        tdata_next = '0;
        comp       = '0;
        for (int i = 0; i < 3; i++)
        begin
            comp = div_side.neg[i] ? OW'(-OW'(div_quo[i])) : OW'(div_quo[i]);
            if (div_side.degen)
            begin
                comp = '0;
            end
            tdata_next[i*OW +: OW] = comp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            out_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            tdata_reg <= tdata_next;
            degen_reg <= div_side.degen;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = tdata_reg;
    assign m_tuser[0] = degen_reg;

`ifndef SYNTH
    // A degenerate result carries all-zero components.
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("degenerate result with nonzero components");

    // After normalization the length is at least 2^30 for a nonzero product.
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_valid && !sqrt_side.degen |-> sqrt_root[ROOT_BITS-1:NORM_TOP] != '0)
        else $error("length below normalized range");

    // No quotient exceeds one in the output format.
    a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
        div_valid && !div_side.degen |->
            (!div_quo[0][NORMAL_FRAC_BITS] || div_quo[0][NORMAL_FRAC_BITS-1:0] == '0) &&
            (!div_quo[1][NORMAL_FRAC_BITS] || div_quo[1][NORMAL_FRAC_BITS-1:0] == '0) &&
            (!div_quo[2][NORMAL_FRAC_BITS] || div_quo[2][NORMAL_FRAC_BITS-1:0] == '0))
        else $error("normal component above unity");
`endif

endmodule
`default_nettype wire

// ===== dv/triangle_unit_normal_chk.sv =====
// Checker for the triangle unit normal block: predicts each normal and compares results.
`timescale 1ns / 100ps
`default_nettype none
module triangle_unit_normal_chk (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [143:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [47:0]  m_tdata,
    input  logic [0:0]   m_tuser,
    output int           fail_count,
    output int           pending
);

    typedef struct packed {
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
        logic        degen;
    } normal_t;

    // Expected normals in transfer order, kept in a ring indexed by two pointers.
    normal_t     due_mem [2048];
    logic [10:0] wr_ptr;
    logic [10:0] rd_ptr;
    int          due_count;

    // Integer square root, floor.
    function automatic longint unsigned root_floor(input longint unsigned num);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > num)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (num >= res + bitv)
            begin
                num = num - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic normal_t triangle_normal(input logic [143:0] d);
        longint          a[3];
        longint          b[3];
        longint          c[3];
        longint unsigned m[3];
        longint unsigned mx;
        longint unsigned len;
        longint unsigned q;
        longint          base;
        normal_t         r;
        logic [15:0]     v[3];
        for (int i = 0; i < 3; i++)
        begin
            base = longint'($signed(d[(6+i)*16 +: 16]));
            a[i] = longint'($signed(d[i*16 +: 16])) - base;
            b[i] = longint'($signed(d[(3+i)*16 +: 16])) - base;
        end
        // Edges of 16-bit coordinates fit in 17 bits signed; no edge scaling needed.
        c[0] = a[1] * b[2] - b[1] * a[2];
        c[1] = a[2] * b[0] - a[0] * b[2];
        c[2] = a[0] * b[1] - b[0] * a[1];
        for (int i = 0; i < 3; i++)
            m[i] = (c[i] < 0) ? -c[i] : c[i];
        mx = m[0];
        if (m[1] > mx) mx = m[1];
        if (m[2] > mx) mx = m[2];
        r = '0;
        if (mx == 0)
        begin
            r.degen = 1'b1;
            return r;
        end
        // Block normalize so the largest magnitude lies in [2^30, 2^31).
        while (mx >= (64'd1 << 31))
        begin
            for (int i = 0; i < 3; i++)
                m[i] = m[i] >> 1;
            mx = mx >> 1;
        end
        while (mx < (64'd1 << 30))
        begin
            for (int i = 0; i < 3; i++)
                m[i] = m[i] << 1;
            mx = mx << 1;
        end
        len = root_floor(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
        for (int i = 0; i < 3; i++)
        begin
            q    = ((m[i] << 14) + (len >> 1)) / len;
            v[i] = (c[i] < 0) ? 16'(-q) : 16'(q);
        end
        r.nx = v[0];
        r.ny = v[1];
        r.nz = v[2];
        return r;
    endfunction

    assign pending = due_count;

    always @(posedge clk or negedge rst_n)
    begin
        normal_t exp_n;
        normal_t got;
        int      count_next;
        if (!rst_n)
        begin
            fail_count <= 0;
            wr_ptr     <= '0;
            rd_ptr     <= '0;
            due_count  <= 0;
        end
        else
        begin
            count_next = due_count;
            if (s_tvalid && s_tready)
            begin
                due_mem[wr_ptr] <= triangle_normal(s_tdata);
                wr_ptr          <= wr_ptr + 11'd1;
                count_next      = count_next + 1;
            end
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tuser[0]};
                if (due_count == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result transfer %h", got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_n      = due_mem[rd_ptr];
                    rd_ptr     <= rd_ptr + 11'd1;
                    count_next = count_next - 1;
                    if (got !== exp_n)
                    begin
                        if (fail_count < 10)
                            $display({"normal mismatch: expected x=%h y=%h z=%h deg=%b,",
                                      " got x=%h y=%h z=%h deg=%b"},
                                     exp_n.nx, exp_n.ny, exp_n.nz, exp_n.degen,
                                     got.nx, got.ny, got.nz, got.degen);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            due_count <= count_next;
        end
    end

endmodule
`default_nettype wire

// ===== dv/triangle_unit_normal_tb.sv =====
// Testbench top for the triangle unit normal block: stimulus, stalls and verdict.
`timescale 1ns / 100ps
`default_nettype none
module triangle_unit_normal_tb;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    // From bit 0 up: first_x/y/z, second_x/y/z, origin_x/y/z, 16 bits each.
    logic [143:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    // From bit 0 up: normal_x, normal_y, normal_z, 16 bits each.
    logic [47:0]  m_tdata;
    // Bit 0: degenerate.
    logic [0:0]   m_tuser;
    int           fail_count;
    int           pending;
    int           cycle_count;
    // While set, neither side idles; used for a stretch of full-rate traffic.
    logic         no_idle;

    localparam int LATENCY = 58;
    localparam int CYCLE_LIMIT = 200000;

    triangle_unit_normal i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    triangle_unit_normal_chk i_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Receiver stalls about 30 percent of the time, except in the no-idle stretch.
    always @(posedge clk)
    begin
        m_tready <= no_idle || ($urandom_range(99) >= 30);
    end

    // Timeout watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("triangle_unit_normal_tb: errors");
            $finish;
        end
    end

    // Coordinate value: mostly random, sometimes an extreme or a small value.
    function automatic logic [15:0] pick_coord();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0)
            return 16'h8000;
        if (sel == 1)
            return 16'h7fff;
        if (sel == 2)
            return 16'($signed($urandom_range(16)) - 8);
        return 16'($urandom);
    endfunction

    // Sends one triangle, with random gaps before it unless no_idle is set.
    task automatic send_triangle(input logic [143:0] tri_data);
        while (!no_idle && $urandom_range(99) < 30)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= tri_data;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    function automatic logic [143:0] pack_tri(input logic [15:0] c[9]);
        logic [143:0] d;
        for (int i = 0; i < 9; i++)
            d[i*16 +: 16] = c[i];
        return d;
    endfunction

    initial
    begin
        logic [15:0] c[9];
        logic [143:0] d;
        int kind;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        no_idle     = 1'b0;
        cycle_count = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: axis-aligned plain form, extremes, collinear and coincident points, then random triangles.
        for (int k = 0; k < 20; k++)
        begin
            foreach (c[i]) c[i] = 16'h0000;
            case (k)
                0: begin c[0] = 16'd64; c[4] = 16'd64; end
                1: begin c[1] = 16'd64; c[5] = 16'd64; end
                2: begin c[2] = 16'd64; c[3] = 16'd64; end
                3: ;
                4: begin c[0] = 16'd5; c[3] = 16'd10; end
                5: foreach (c[i]) c[i] = 16'h7fff;
                6: begin c[0] = 16'h7fff; c[4] = 16'h7fff; foreach (c[i]) if (i >= 6) c[i] = 16'h8000; end
                7: begin c[0] = 16'h8000; c[4] = 16'h8000; c[8] = 16'h7fff; end
                8: begin c[0] = 16'h7fff; c[1] = 16'h8000; c[5] = 16'h7fff; c[3] = 16'h8000; end
                9: begin c[0] = 16'd1; c[4] = 16'd1; end
                10: begin c[0] = 16'hffff; c[4] = 16'd1; c[8] = 16'hffff; end
                11: begin c[0] = 16'd1; c[1] = 16'd1; c[2] = 16'd1; c[3] = 16'd2; c[4] = 16'd2; c[5] = 16'd2; end
                12: begin c[0] = 16'h8000; c[1] = 16'h7fff; c[2] = 16'h8000;
                          c[3] = 16'h7fff; c[4] = 16'h8000; c[5] = 16'h7fff; end
                13: begin c[0] = 16'd3; c[1] = 16'd4; c[4] = 16'd1; end
                default: foreach (c[i]) c[i] = pick_coord();
            endcase
            send_triangle(pack_tri(c));
        end

        // Hold off until the directed results have all arrived.
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);

        for (int n = 0; n < 1500; n++)
        begin
            no_idle <= (n >= 600 && n < 800);
            kind = $urandom_range(9);
            foreach (c[i]) c[i] = pick_coord();
            if (kind == 0)
            begin
                // Collinear: second point is a scaled first edge.
                for (int i = 0; i < 3; i++)
                    c[3+i] = c[6+i] + 16'($signed(c[i] - c[6+i]) >>> 1);
                for (int i = 0; i < 3; i++)
                    c[i] = c[6+i] + 16'(2 * $signed(16'($signed(c[3+i] - c[6+i]))));
            end
            else if (kind == 1)
                for (int i = 6; i < 9; i++) c[i] = 16'h0000;
            else if (kind == 2)
                for (int i = 0; i < 3; i++) c[3+i] = c[i];
            d = pack_tri(c);
            send_triangle(d);
        end
        s_tvalid <= 1'b0;
        no_idle  <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (fail_count == 0)
            $display("triangle_unit_normal_tb: clean");
        else
            $display("triangle_unit_normal_tb: errors");
        $finish;
    end

endmodule
`default_nettype wire

// ===== sim.f =====
sv/tun_pkg.sv
sv/tun_front.sv
sv/tun_norm.sv
sv/tun_sqrt.sv
sv/tun_div.sv
sv/triangle_unit_normal.sv
dv/triangle_unit_normal_chk.sv
dv/triangle_unit_normal_tb.sv
